@@ hdl/ptu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_pkg
// Shared types and constants for the prefixed text to uint32 parser.
// ----------------------------------------------------------------------------
package ptu_pkg;

    // Prefix kinds seen at the head of the string.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HASH = 2'd1;
    localparam logic [1:0] KIND_OX   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DEC      = 2'd0;
    localparam logic [1:0] ST_HEX      = 2'd1;
    localparam logic [1:0] ST_FALLBACK = 2'd2;

    // Digit limits and character codes.
    localparam logic [3:0] DEC_MAX_DIGITS = 4'd10;
    localparam logic [3:0] HEX_MAX_DIGITS = 4'd8;
    localparam logic [3:0] COUNT_SAT      = 4'd15;
    localparam logic [7:0] CH_HASH        = 8'h23;
    localparam logic [7:0] CH_ZERO        = 8'h30;
    localparam logic [7:0] CH_NINE        = 8'h39;
    localparam logic [7:0] CH_UPPER_X     = 8'h58;
    localparam logic [7:0] CH_LOWER_X     = 8'h78;

    // Classification of one character.
    typedef struct packed {
        logic       is_digit;
        logic       is_hex;
        logic [3:0] hex_val;   // also the decimal value when is_digit is set
        logic       is_hash;
        logic       is_zero;
        logic       is_x;
    } t_char_class;

endpackage

@@ hdl/prefixed_text_to_uint32.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefixed_text_to_uint32
// Streaming parser of an unsigned 32-bit number from ASCII text, one
// character per transfer, decimal or hexadecimal ('#', "0x", "0X" prefix).
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Carries
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | one character, no-character flag, end of text, fallback
//  m_axis   | out       | parsed value and status, one per string
//
// A character enters the input register; when it moves on, the parse state is
// updated from it and, on the final character, the result is written to the
// output register. A new character is accepted in every cycle unless a final
// character is held. A waiting result stalls only the final character of the
// next string; other characters keep flowing. Reset clears both registers'
// valid flags and returns the parse state to its start values.
//
module prefixed_text_to_uint32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] text_char, [39:8] fallback
    input  logic        s_axis_tlast,   // end_of_text
    input  logic        s_axis_tuser,   // no_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] parsed_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import ptu_pkg::*;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_no_char;
    logic        r_in_last;
    logic [31:0] r_in_fallback;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic [1:0]  r_out_status;

    logic        w_out_free;
    logic        w_advance;
    logic [31:0] w_value;
    logic [1:0]  w_status;

    // A character that produces no result never waits on the output side.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char     <= s_axis_tdata[7:0];
            r_in_fallback <= s_axis_tdata[39:8];
            r_in_no_char  <= s_axis_tuser;
            r_in_last     <= s_axis_tlast;
        end
    end

    ptu_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_char     (r_in_char),
        .i_no_char  (r_in_no_char),
        .i_last     (r_in_last),
        .i_fallback (r_in_fallback),
        .o_value    (w_value),
        .o_status   (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_value  <= w_value;
            r_out_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    // A final character never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_advance && r_in_last && r_out_valid && !m_axis_tready))
        else $error("result register overwritten before transfer");

    // A held character stays in the input register until it is processed.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input character lost while stalled");

    // A character that is not final always moves on in its cycle.
    a_mid_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> w_advance)
        else $error("non-final character stalled");

    // Status is one of the three result codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status == ST_DEC || r_out_status == ST_HEX ||
                         r_out_status == ST_FALLBACK))
        else $error("invalid status code");

endmodule

@@ hdl/ptu_char_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_char_decode
// Classifies one ASCII character for the decimal and hexadecimal paths.
// ----------------------------------------------------------------------------
module ptu_char_decode (
    input  logic [7:0]           i_char,
    output ptu_pkg::t_char_class o_class
);
    import ptu_pkg::*;

    logic w_upper;
    logic w_lower;

    // Letters A-F and a-f have low nibbles 1 to 6, so adding 9 gives 10 to 15.
    assign w_upper = (i_char >= 8'h41) && (i_char <= 8'h46);
    assign w_lower = (i_char >= 8'h61) && (i_char <= 8'h66);

    always_comb begin
        o_class.is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        o_class.is_hex   = o_class.is_digit || w_upper || w_lower;
        o_class.hex_val  = o_class.is_digit ? i_char[3:0] : i_char[3:0] + 4'd9;
        o_class.is_hash  = (i_char == CH_HASH);
        o_class.is_zero  = (i_char == CH_ZERO);
        o_class.is_x     = (i_char == CH_UPPER_X) || (i_char == CH_LOWER_X);
    end

endmodule

@@ hdl/ptu_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_accum
// Per-string parse state, updated by one character a step, and the result
// that the final character of a string selects.
// ----------------------------------------------------------------------------
module ptu_accum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_char,
    input  logic        i_no_char,
    input  logic        i_last,
    input  logic [31:0] i_fallback,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);
    import ptu_pkg::*;

    t_char_class w_cls;

    logic [3:0]  r_char_count, n_char_count;
    logic [1:0]  r_prefix_kind, n_prefix_kind;
    logic        r_first_zero, n_first_zero;
    logic [31:0] r_dec_sum, n_dec_sum;
    logic        r_dec_ok, n_dec_ok;
    logic [31:0] r_hex_sum, n_hex_sum;
    logic        r_hex_ok, n_hex_ok;
    logic [3:0]  r_hex_count, n_hex_count;
    logic        w_take_hex;
    logic        w_hex_path;

    ptu_char_decode u_decode (
        .i_char  (i_char),
        .o_class (w_cls)
    );

    always_comb begin
        n_char_count  = r_char_count;
        n_prefix_kind = r_prefix_kind;
        n_first_zero  = r_first_zero;
        n_dec_sum     = r_dec_sum;
        n_dec_ok      = r_dec_ok;
        n_hex_sum     = r_hex_sum;
        n_hex_ok      = r_hex_ok;
        n_hex_count   = r_hex_count;
        w_take_hex    = 1'b0;

        if (!i_no_char) begin
            // Decimal path runs over every character.
            if (w_cls.is_digit) begin
                n_dec_sum = (r_dec_sum << 3) + (r_dec_sum << 1) + {28'd0, w_cls.hex_val};
            end else begin
                n_dec_ok = 1'b0;
            end

            // Prefix detection decides which characters feed the hex path.
            if (r_char_count == 4'd0) begin
                if (w_cls.is_hash) begin
                    n_prefix_kind = KIND_HASH;
                end else if (w_cls.is_zero) begin
                    n_first_zero = 1'b1;
                end
            end else if (r_char_count == 4'd1) begin
                if (r_prefix_kind == KIND_HASH) begin
                    w_take_hex = 1'b1;
                end else if (r_first_zero && w_cls.is_x) begin
                    n_prefix_kind = KIND_OX;
                end
            end else if (r_prefix_kind != KIND_NONE) begin
                w_take_hex = 1'b1;
            end

            if (w_take_hex) begin
                if (w_cls.is_hex) begin
                    n_hex_sum = {r_hex_sum[27:0], w_cls.hex_val};
                end else begin
                    n_hex_ok = 1'b0;
                end
                if (r_hex_count != COUNT_SAT) begin
                    n_hex_count = r_hex_count + 4'd1;
                end
            end

            if (r_char_count != COUNT_SAT) begin
                n_char_count = r_char_count + 4'd1;
            end
        end
    end

    // Result from the state that includes the final character.
    assign w_hex_path = ((n_prefix_kind == KIND_HASH) && (n_char_count > 4'd1)) ||
                        ((n_prefix_kind == KIND_OX) && (n_char_count > 4'd2));

    always_comb begin
        o_value  = i_fallback;
        o_status = ST_FALLBACK;
        if (n_char_count == 4'd0) begin
            o_value  = i_fallback;
        end else if (w_hex_path) begin
            if (n_hex_ok && (n_hex_count != 4'd0) && (n_hex_count <= HEX_MAX_DIGITS)) begin
                o_value  = n_hex_sum;
                o_status = ST_HEX;
            end
        end else if (n_dec_ok && (n_char_count <= DEC_MAX_DIGITS)) begin
            o_value  = n_dec_sum;
            o_status = ST_DEC;
        end
    end

    // The final item of a string returns all state to its start values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_char_count  <= 4'd0;
            r_prefix_kind <= KIND_NONE;
            r_first_zero  <= 1'b0;
            r_dec_sum     <= 32'd0;
            r_dec_ok      <= 1'b1;
            r_hex_sum     <= 32'd0;
            r_hex_ok      <= 1'b1;
            r_hex_count   <= 4'd0;
        end else if (i_step) begin
            r_char_count  <= n_char_count;
            r_prefix_kind <= n_prefix_kind;
            r_first_zero  <= n_first_zero;
            r_dec_sum     <= n_dec_sum;
            r_dec_ok      <= n_dec_ok;
            r_hex_sum     <= n_hex_sum;
            r_hex_ok      <= n_hex_ok;
            r_hex_count   <= n_hex_count;
        end
    end

endmodule

@@ dv/prefixed_text_to_uint32_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefixed_text_to_uint32_tb
// Streams ASCII strings into the parser one character per transfer and checks
// every parsed value and status against a cycle-free parser kept in the bench.
// ----------------------------------------------------------------------------
module prefixed_text_to_uint32_tb;
    import ptu_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CHARS_PER_RUN = 330;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    typedef struct packed {
        logic [31:0] fallback;
        logic [7:0]  text_char;
        logic        end_of_text;
        logic        no_char;
    } t_char_item;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_number;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [7:0] text_char, [39:8] fallback
    logic        s_axis_tlast = 1'b0; // end_of_text
    logic        s_axis_tuser = 1'b0; // no_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] parsed_value
    logic [1:0]  m_axis_tuser;        // [1:0] status

    t_char_item  pending_chars[$];
    t_number     expected_numbers[$];
    logic [7:0]  text_buf[$];
    int          chars_queued = 0;
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          in_took = 1'b0;

    // Parser state of the bench copy.
    logic [3:0]  char_cnt;
    logic [1:0]  prefix;
    logic        lead_zero;
    logic [31:0] dec_sum;
    logic        dec_ok;
    logic [31:0] hex_sum;
    logic        hex_ok;
    logic [3:0]  hex_cnt;

    prefixed_text_to_uint32 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench parser
    // ------------------------------------------------------------------
    task automatic clear_parser();
        char_cnt  = '0;
        prefix    = KIND_NONE;
        lead_zero = 1'b0;
        dec_sum   = '0;
        dec_ok    = 1'b1;
        hex_sum   = '0;
        hex_ok    = 1'b1;
        hex_cnt   = '0;
    endtask

    // Digit value, or 16 when the character is no hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd16;
        if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) d = c - CH_UPPER_A + 8'd10;
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) d = c - CH_LOWER_A + 8'd10;
        return d[4:0];
    endfunction

    task automatic take_hex_char(input logic [7:0] c);
        logic [4:0] v;
        v = hex_digit(c);
        if (v[4]) hex_ok = 1'b0;
        else hex_sum = {hex_sum[27:0], v[3:0]};
        if (hex_cnt != COUNT_SAT) hex_cnt = hex_cnt + 4'd1;
    endtask

    task automatic parse_step(input t_char_item it);
        t_number r;
        logic    hex_path;
        if (!it.no_char) begin
            if (it.text_char >= CH_ZERO && it.text_char <= CH_NINE)
                dec_sum = dec_sum * 32'd10 + {24'd0, it.text_char - CH_ZERO};
            else
                dec_ok = 1'b0;

            if (char_cnt == 4'd0) begin
                if (it.text_char == CH_HASH) prefix = KIND_HASH;
                else if (it.text_char == CH_ZERO) lead_zero = 1'b1;
            end else if (char_cnt == 4'd1) begin
                if (prefix == KIND_HASH)
                    take_hex_char(it.text_char);
                else if (lead_zero &&
                         (it.text_char == CH_LOWER_X || it.text_char == CH_UPPER_X))
                    prefix = KIND_OX;
            end else if (prefix != KIND_NONE) begin
                take_hex_char(it.text_char);
            end

            if (char_cnt != COUNT_SAT) char_cnt = char_cnt + 4'd1;
        end

        if (it.end_of_text) begin
            r.value  = it.fallback;
            r.status = ST_FALLBACK;
            // A lone prefix does not count: it falls back to the decimal path.
            hex_path = (prefix == KIND_HASH && char_cnt > 4'd1) ||
                       (prefix == KIND_OX && char_cnt > 4'd2);
            if (char_cnt == 4'd0) begin
                // Empty string keeps the fallback.
            end else if (hex_path) begin
                if (hex_ok && hex_cnt >= 4'd1 && hex_cnt <= HEX_MAX_DIGITS) begin
                    r.value  = hex_sum;
                    r.status = ST_HEX;
                end
            end else if (dec_ok && char_cnt <= DEC_MAX_DIGITS) begin
                r.value  = dec_sum;
                r.status = ST_DEC;
            end
            expected_numbers.push_back(r);
            clear_parser();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] c, input logic none, input logic fin,
                             input logic [31:0] fb);
        t_char_item it;
        it.text_char   = c;
        it.no_char     = none;
        it.end_of_text = fin;
        it.fallback    = fb;
        pending_chars.push_back(it);
        if (!none) chars_queued++;
    endtask

    // Sends text_buf as one string; gaps are stray no-character transfers, and
    // close_none ends the string with a no-character final transfer.
    task automatic emit_text(input logic [31:0] fb, input int gap_pct, input bit close_none);
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < gap_pct)
                push_char(8'($urandom_range(255)), 1'b1, 1'b0, $urandom);
            push_char(text_buf[i], 1'b0, (i == n - 1) && !close_none, fb);
        end
        if (close_none || n == 0)
            push_char(8'($urandom_range(255)), 1'b1, 1'b1, fb);
    endtask

    task automatic add_literal(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic add_dec_digits(input int n);
        for (int i = 0; i < n; i++) text_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
    endtask

    task automatic add_hex_digits(input int n);
        int v;
        for (int i = 0; i < n; i++) begin
            v = $urandom_range(15);
            if (v < 10) text_buf.push_back(8'(CH_ZERO + v));
            else if ($urandom_range(1)) text_buf.push_back(8'(CH_UPPER_A + v - 10));
            else text_buf.push_back(8'(CH_LOWER_A + v - 10));
        end
    endtask

    task automatic add_hex_text();
        int p;
        int n;
        p = $urandom_range(2);
        if (p == 0) add_literal("#");
        else if (p == 1) add_literal("0x");
        else add_literal("0X");
        if ($urandom_range(7) == 0) n = $urandom_range(1) ? 0 : $urandom_range(9, 12);
        else n = $urandom_range(1, 8);
        add_hex_digits(n);
    endtask

    function automatic logic [31:0] pick_fallback();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Mostly well-formed numbers, then corrupted ones and plain noise.
    task automatic make_random_text();
        int    pick;
        int    pos;
        int    len;
        string tricky;
        tricky = "#0xX9aF";
        text_buf.delete();
        pick = $urandom_range(99);
        if (pick < 35) begin
            if ($urandom_range(9) == 0) add_dec_digits($urandom_range(11, 18));
            else add_dec_digits($urandom_range(1, 10));
        end else if (pick < 70) begin
            add_hex_text();
        end else if (pick < 85) begin
            if ($urandom_range(1)) add_dec_digits($urandom_range(1, 10));
            else add_hex_text();
            pos = $urandom_range(text_buf.size() - 1);
            text_buf[pos] = 8'($urandom_range(255));
        end else begin
            len = $urandom_range(1, 18);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(1)) text_buf.push_back(8'($urandom_range(255)));
                else text_buf.push_back(tricky[$urandom_range(tricky.len() - 1)]);
            end
        end
    endtask

    task automatic run_random_strings(input int target);
        int stop_at;
        stop_at = chars_queued + target;
        while (chars_queued < stop_at) begin
            make_random_text();
            emit_text(pick_fallback(), 6, $urandom_range(99) < 15);
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || s_axis_tvalid || expected_numbers.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: new transfer values are placed at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic       next_valid;
        t_char_item it;
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_took) begin
                next_valid = 1'b0;
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it           = pending_chars.pop_front();
                    s_axis_tdata <= {it.fallback, it.text_char};
                    s_axis_tlast <= it.end_of_text;
                    s_axis_tuser <= it.no_char;
                    next_valid   = 1'b1;
                end
                s_axis_tvalid <= next_valid;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both channels are sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_item it;
        t_number    want;
        if (i_rst_n) begin
            in_took = s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                it.text_char   = s_axis_tdata[7:0];
                it.fallback    = s_axis_tdata[39:8];
                it.end_of_text = s_axis_tlast;
                it.no_char     = s_axis_tuser;
                parse_step(it);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_numbers.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got value %h status %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = expected_numbers.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $display("%0t: parsed_value expected %h, got %h",
                                 $time, want.value, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_parser();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed strings, no idling.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        text_buf.delete();
        emit_text(32'hFFFF_FFFF, 0, 1'b0);          // empty string
        add_literal("#");
        emit_text(32'h0000_0000, 0, 1'b0);          // lone hash
        text_buf.delete();
        add_literal("0X");
        emit_text($urandom, 0, 1'b0);               // bare hex prefix
        text_buf.delete();
        add_literal("#fA");
        emit_text($urandom, 0, 1'b0);
        text_buf.delete();
        add_literal("0x0");
        emit_text($urandom, 0, 1'b0);
        text_buf.delete();
        add_literal("9999999999");                  // ten digits that wrap
        emit_text($urandom, 0, 1'b0);
        // Stray no-character transfer, then a no-character final closes "7".
        push_char(CH_ZERO + 8'd7, 1'b0, 1'b0, $urandom);
        push_char(8'hFF, 1'b1, 1'b0, $urandom);
        push_char(8'h00, 1'b1, 1'b1, $urandom);
        wait_drained();

        run_random_strings(CHARS_PER_RUN);
        wait_drained();

        send_idle_pct = 68;
        run_random_strings(CHARS_PER_RUN);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 68;
        run_random_strings(CHARS_PER_RUN);
        wait_drained();

        send_idle_pct  = 29;
        recv_stall_pct = 29;
        run_random_strings(CHARS_PER_RUN);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ prefixed_text_to_uint32.f @@
hdl/ptu_pkg.sv
hdl/ptu_char_decode.sv
hdl/ptu_accum.sv
hdl/prefixed_text_to_uint32.sv
dv/prefixed_text_to_uint32_tb.sv
